### rtl/core/spline_volume_partial_derivative_defines.svh
// Assertion macros for the spline volume derivative block.
`ifndef SPLINE_VOLUME_PARTIAL_DERIVATIVE_DEFINES_SVH
`define SPLINE_VOLUME_PARTIAL_DERIVATIVE_DEFINES_SVH
// Asserts that an antecedent implies a consequent in the next cycle.
`define SVPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
// Asserts that a condition holds at every edge.
`define SVPD_ASSERT_ALWAYS(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("check failed");
`endif

### rtl/core/svpd_pkg.sv
// ----------------------------------------------------------------------------
// svpd_pkg
// Types and constants shared by the spline volume derivative block.
// ----------------------------------------------------------------------------
package svpd_pkg;
  localparam int MaxLen = 16;
  localparam int MaxKnots = 32;
  localparam int FracBits = 16;
  localparam int DelayDepth = MaxLen * MaxLen;
  localparam int PtrW = $clog2(DelayDepth);
  localparam int KnotW = $clog2(MaxKnots);
  localparam int LenW = 5;
  localparam int DivCycles = 64;

  localparam logic [2:0] RegKind = 3'd0;
  localparam logic [2:0] RegDir = 3'd1;
  localparam logic [2:0] RegULen = 3'd2;
  localparam logic [2:0] RegVLen = 3'd3;
  localparam logic [2:0] RegWLen = 3'd4;
  localparam logic [2:0] RegOrder = 3'd5;
  localparam logic [2:0] RegRational = 3'd6;
  localparam logic [2:0] RegScalar = 3'd7;

  localparam logic CmdKnot = 1'b0;
  localparam logic CmdPoint = 1'b1;

  typedef struct packed {
    logic start;
    logic [31:0] point;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;
endpackage

### rtl/core/svpd_ctrl.sv
// ----------------------------------------------------------------------------
// svpd_ctrl
// Sequencer: accepts point requests, starts the datapath, waits until the result is taken.
// ----------------------------------------------------------------------------
module svpd_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic pt_valid_i,
  input  logic [31:0] pt_i,
  output logic pt_ready_o,
  input  svpd_pkg::stat_t stat_i,
  output svpd_pkg::cmd_t cmd_o
);
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StWait = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign pt_ready_o = (state_q == StIdle);
  assign cmd_o.start = pt_valid_i && pt_ready_o;
  assign cmd_o.point = pt_i;
  assign cmd_o.take = (state_q == StRun) && stat_i.done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (cmd_o.start) state_d = StRun;
      StRun: if (stat_i.done) state_d = StWait;
      StWait: if (!stat_i.busy) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end
endmodule

### rtl/core/svpd_dp.sv
// ----------------------------------------------------------------------------
// svpd_dp
// Datapath: registers, knots, delay line, counters, divider, output stage.
// ----------------------------------------------------------------------------
module svpd_dp (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic knot_we_i,
  input  logic [4:0] knot_index_i,
  input  logic [31:0] knot_value_i,
  input  svpd_pkg::cmd_t cmd_i,
  output svpd_pkg::stat_t stat_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output logic [31:0] m_deriv_o,
  output logic m_status_o,
  output logic m_last_o
);
  localparam int PW = svpd_pkg::PtrW;
  localparam int LW = svpd_pkg::LenW;
  localparam int CW = $clog2(svpd_pkg::DivCycles + 4);

  logic kind_q, rat_q, scal_q;
  logic [1:0] dir_q;
  logic [LW-1:0] ul_q, vl_q, wl_q, ord_q;
  logic [LW-1:0] uc_q, vc_q, wc_q, uc_d, vc_d, wc_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [31:0] delay_mem [svpd_pkg::DelayDepth];
  logic [31:0] knot_mem [svpd_pkg::MaxKnots];

  function automatic logic [LW-1:0] clampl(input logic [LW-1:0] l);
    if (l == '0) return LW'(1);
    if (l > LW'(svpd_pkg::MaxLen)) return LW'(svpd_pkg::MaxLen);
    return l;
  endfunction

  logic [LW-1:0] ul, vl, wl, u0, v0, w0, pos, len;
  logic [PW:0] stride;
  logic [PW-1:0] rd;
  assign ul = clampl(ul_q);
  assign vl = clampl(vl_q);
  assign wl = clampl(wl_q);
  assign u0 = (uc_q >= ul) ? '0 : uc_q;
  assign v0 = (vc_q >= vl) ? '0 : vc_q;
  assign w0 = (wc_q >= wl) ? '0 : wc_q;

  always_comb begin
    unique case (dir_q)
      2'd0: begin pos = u0; len = ul; stride = (PW+1)'(1); end
      2'd1: begin pos = v0; len = vl; stride = (PW+1)'(ul); end
      default: begin pos = w0; len = wl; stride = (PW+1)'(ul * vl); end
    endcase
  end
  assign rd = PW'(wp_q - stride[PW-1:0]);

  always_comb begin
    uc_d = u0 + LW'(1);
    vc_d = v0;
    wc_d = w0;
    wp_d = wp_q + PW'(1);
    if (uc_d >= ul) begin
      uc_d = '0;
      vc_d = v0 + LW'(1);
      if (vc_d >= vl) begin
        vc_d = '0;
        wc_d = w0 + LW'(1);
        if (wc_d >= wl) begin
          wc_d = '0;
          wp_d = '0;
        end
      end
    end
  end

  // Captured decisions for the running point.
  logic [31:0] cur_q, prev_q;
  logic [1:0] mode_q; // 0 zero, 1 bezier, 2 bspline, 3 none
  logic stat_q, last_q;
  logic [LW-1:0] pos_q, len_q;
  logic [CW-1:0] cnt_q;
  logic run_q;
  logic [LW:0] ki1, ki2;
  logic [31:0] k1_q, k2_q;

  always_ff @(posedge clk_i) begin
    if (knot_we_i) knot_mem[knot_index_i] <= knot_value_i;
    if (cmd_i.start) begin
      delay_mem[wp_q] <= cmd_i.point;
      prev_q <= delay_mem[rd];
    end
    k1_q <= (ki1 < (LW+1)'(svpd_pkg::MaxKnots)) ? knot_mem[ki1[LW-1:0]] : '0;
    k2_q <= (ki2 < (LW+1)'(svpd_pkg::MaxKnots)) ? knot_mem[ki2[LW-1:0]] : '0;
  end
  assign ki1 = (LW+1)'(pos_q) - (LW+1)'(1) + (LW+1)'(ord_q);
  assign ki2 = (LW+1)'(pos_q);

  // Divider: magnitude restoring division, one bit a cycle.
  localparam int NW = svpd_pkg::DivCycles - 4;
  logic [NW-1:0] quo_q, rem_q;
  logic [32:0] dmag_q;
  logic neg_q;
  logic signed [32:0] diff_s;
  logic signed [38:0] prodv;
  logic signed [38:0] bez;
  logic signed [32:0] den;
  logic [NW:0] trial;

  assign diff_s = $signed({cur_q[31], cur_q}) - $signed({prev_q[31], prev_q});
  assign den = $signed({k1_q[31], k1_q}) - $signed({k2_q[31], k2_q});
  assign trial = {rem_q, quo_q[NW-1]} - {{(NW-32){1'b0}}, dmag_q};
  assign bez = diff_s * $signed({1'b0, len_q - LW'(1)});

  function automatic logic [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0; dir_q <= '0; rat_q <= 1'b0; scal_q <= 1'b0;
      ul_q <= LW'(1); vl_q <= LW'(1); wl_q <= LW'(1); ord_q <= LW'(1);
      uc_q <= '0; vc_q <= '0; wc_q <= '0; wp_q <= '0;
      run_q <= 1'b0; cnt_q <= '0; m_tvalid_o <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) m_tvalid_o <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          svpd_pkg::RegKind: kind_q <= cfg_data_i[0];
          svpd_pkg::RegDir: dir_q <= cfg_data_i[1:0];
          svpd_pkg::RegULen: ul_q <= cfg_data_i[LW-1:0];
          svpd_pkg::RegVLen: vl_q <= cfg_data_i[LW-1:0];
          svpd_pkg::RegWLen: wl_q <= cfg_data_i[LW-1:0];
          svpd_pkg::RegOrder: ord_q <= cfg_data_i[LW-1:0];
          svpd_pkg::RegRational: rat_q <= cfg_data_i[0];
          default: scal_q <= cfg_data_i[0];
        endcase
        uc_q <= '0; vc_q <= '0; wc_q <= '0; wp_q <= '0;
      end
      if (cmd_i.start) begin
        uc_q <= uc_d; vc_q <= vc_d; wc_q <= wc_d; wp_q <= wp_d;
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cmd_i.take) run_q <= 1'b0;
      end
      if (cmd_i.take && mode_q != 2'd3) m_tvalid_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q <= cmd_i.point;
      pos_q <= pos;
      len_q <= len;
      stat_q <= rat_q && (kind_q || !scal_q);
      last_q <= (u0 + LW'(1) == ul) && (v0 + LW'(1) == vl) && (w0 + LW'(1) == wl);
      if (rat_q && (kind_q || !scal_q)) mode_q <= 2'd0;
      else if (dir_q == 2'd3) mode_q <= 2'd3;
      else if (!kind_q) mode_q <= (len < LW'(2)) ? 2'd0 : (pos != '0) ? 2'd1 : 2'd3;
      else mode_q <= (ord_q < LW'(2)) ? 2'd0 : (pos != '0) ? 2'd2 : 2'd3;
    end
    if (cnt_q == CW'(1)) begin
      prodv <= 39'(diff_s) * $signed({1'b0, ord_q - LW'(1)});
      dmag_q <= (den == 0) ? 33'd1 : den[32] ? 33'(-den) : 33'(den);
      neg_q <= den[32];
    end
    if (cnt_q == CW'(3)) begin
      neg_q <= neg_q ^ prodv[38];
      quo_q <= NW'(prodv[38] ? -prodv : prodv) << svpd_pkg::FracBits;
      rem_q <= '0;
    end else if (cnt_q > CW'(3) && cnt_q <= CW'(3 + NW/2 + NW/2)) begin
      if (!trial[NW]) begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NW-2:0], quo_q[NW-1]};
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.take) begin
      m_status_o <= stat_q;
      m_last_o <= last_q;
      unique case (mode_q)
        2'd1: m_deriv_o <= sat(64'(bez));
        2'd2: m_deriv_o <= sat(neg_q ? -$signed({4'b0, quo_q}) : $signed({4'b0, quo_q}));
        default: m_deriv_o <= '0;
      endcase
    end
  end

  assign stat_o.done = run_q && (cnt_q == CW'(svpd_pkg::DivCycles));
  assign stat_o.busy = m_tvalid_o;
endmodule

### rtl/core/spline_volume_partial_derivative.sv
// ----------------------------------------------------------------------------
// spline_volume_partial_derivative
// Top level: derivative of a Bezier or B-spline control mesh plane.
// ----------------------------------------------------------------------------
// Knot requests are taken at any time. A point request is taken only while
// the block is idle; its result is presented once the bit-serial divider of
// the knot-difference quotient, which runs for every point, has finished.
// The next point request is accepted only after that result has been taken,
// or after the divider finishes for a point that yields no result; a stalled
// result adds its wait.
module spline_volume_partial_derivative (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [71:0] s_axis_tdata, // knot_index, knot_value, point_value, 3 pad
  input  logic s_axis_tuser,        // cmd
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata, // deriv_value
  output logic m_axis_tuser,        // status
  output logic m_axis_tlast         // last
);
  svpd_pkg::cmd_t cmd;
  svpd_pkg::stat_t stat;
  logic pt_ready;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (s_axis_tuser == svpd_pkg::CmdKnot) ? 1'b1 : pt_ready;

  svpd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .pt_valid_i(s_axis_tvalid && s_axis_tuser == svpd_pkg::CmdPoint),
    .pt_i(s_axis_tdata[68:37]),
    .pt_ready_o(pt_ready),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  svpd_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .knot_we_i(s_axis_tvalid && s_axis_tuser == svpd_pkg::CmdKnot),
    .knot_index_i(s_axis_tdata[4:0]),
    .knot_value_i(s_axis_tdata[36:5]),
    .cmd_i(cmd),
    .stat_o(stat),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_deriv_o(m_axis_tdata),
    .m_status_o(m_axis_tuser),
    .m_last_o(m_axis_tlast)
  );
endmodule

### rtl/core/svpd_checker.sv
// ----------------------------------------------------------------------------
// svpd_port_checker
// Port checks for the spline volume derivative block.
// ----------------------------------------------------------------------------
`include "spline_volume_partial_derivative_defines.svh"
module svpd_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  logic out_stall, pt_take;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign pt_take = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  `SVPD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `SVPD_ASSERT_NEXT(a_busy, clk_i, rst_ni, pt_take, !m_axis_tvalid)
  `SVPD_ASSERT_ALWAYS(a_knot, clk_i, rst_ni, s_axis_tuser || s_axis_tready)
endmodule

bind spline_volume_partial_derivative svpd_port_checker u_svpd_checker (.*);

### tb/svpd_checker.sv
// ----------------------------------------------------------------------------
// svpd_checker
// Watches the configuration, request and result channels of the spline volume
// derivative block, predicts every derivative point and compares each result.
// ----------------------------------------------------------------------------
module svpd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [71:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  input  logic        m_tlast_i,
  output int          pending_o,
  output int          fails_o
);
  typedef struct packed {
    logic [31:0] value;
    logic        status;
    logic        last;
  } deriv_t;

  deriv_t      deriv_q[$];
  logic        kind_r, rational_r, scalar_r;
  logic [1:0]  dir_r;
  logic [4:0]  ulen_r, vlen_r, wlen_r, order_r;
  logic [31:0] delay_mem [svpd_pkg::DelayDepth];
  logic [31:0] knot_mem [svpd_pkg::MaxKnots];
  int unsigned ucnt, vcnt, wcnt, wptr;
  int          fails;

  assign pending_o = deriv_q.size();
  assign fails_o = fails;

  function automatic int unsigned clip_len(logic [4:0] l);
    if (l < 1) return 1;
    if (l > svpd_pkg::MaxLen) return svpd_pkg::MaxLen;
    return l;
  endfunction

  function automatic longint knot_val(int unsigned idx);
    if (idx >= svpd_pkg::MaxKnots) return 0;
    return longint'($signed(knot_mem[idx]));
  endfunction

  task automatic predict_point(input logic [31:0] pv);
    int unsigned ul, vl, wl, pos, len, stride, rd, i;
    longint cur, diff, val, den, num;
    logic emit, st, lst;
    deriv_t d;
    ul = clip_len(ulen_r);
    vl = clip_len(vlen_r);
    wl = clip_len(wlen_r);
    emit = 1'b0;
    st = 1'b0;
    val = 0;
    if (ucnt >= ul) ucnt = 0;
    if (vcnt >= vl) vcnt = 0;
    if (wcnt >= wl) wcnt = 0;
    if (wptr >= svpd_pkg::DelayDepth) wptr = 0;
    cur = longint'($signed(pv));
    if (dir_r == 2'd0) begin
      pos = ucnt; len = ul; stride = 1;
    end else if (dir_r == 2'd1) begin
      pos = vcnt; len = vl; stride = ul;
    end else begin
      pos = wcnt; len = wl; stride = ul * vl;
    end
    rd = (wptr + svpd_pkg::DelayDepth - stride) % svpd_pkg::DelayDepth;
    lst = (ucnt + 1 == ul) && (vcnt + 1 == vl) && (wcnt + 1 == wl);
    if (rational_r && (kind_r || !scalar_r)) begin
      emit = 1'b1; st = 1'b1;
    end else if (dir_r == 2'd3) begin
      emit = 1'b0;
    end else if (!kind_r) begin
      if (len < 2) begin
        emit = 1'b1;
      end else if (pos >= 1) begin
        diff = cur - longint'($signed(delay_mem[rd]));
        emit = 1'b1;
        val = longint'(len - 1) * diff;
      end
    end else begin
      if (order_r < 2) begin
        emit = 1'b1;
      end else if (pos >= 1) begin
        i = pos - 1;
        diff = cur - longint'($signed(delay_mem[rd]));
        den = knot_val(i + order_r) - knot_val(i + 1);
        num = longint'(order_r - 1) * diff * (longint'(1) << svpd_pkg::FracBits);
        if (den == 0) den = 1;
        emit = 1'b1;
        val = num / den;
      end
    end
    delay_mem[wptr] = pv;
    wptr = (wptr + 1) % svpd_pkg::DelayDepth;
    ucnt++;
    if (ucnt >= ul) begin
      ucnt = 0;
      vcnt++;
      if (vcnt >= vl) begin
        vcnt = 0;
        wcnt++;
        if (wcnt >= wl) begin
          wcnt = 0; wptr = 0;
        end
      end
    end
    if (emit) begin
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      d.value = val[31:0];
      d.status = st;
      d.last = lst;
      deriv_q.push_back(d);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deriv_t e;
    if (!rst_ni) begin
      deriv_q.delete();
      kind_r = 0; dir_r = 0; ulen_r = 1; vlen_r = 1; wlen_r = 1;
      order_r = 1; rational_r = 0; scalar_r = 0;
      ucnt = 0; vcnt = 0; wcnt = 0; wptr = 0;
      fails = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (deriv_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result value %h status %b last %b", $time,
                   m_tdata_i, m_tuser_i, m_tlast_i);
        end else begin
          e = deriv_q.pop_front();
          if (e.value !== m_tdata_i) begin
            fails++;
            $display("%0t: deriv_value expected %h actual %h", $time, e.value, m_tdata_i);
          end
          if (e.status !== m_tuser_i) begin
            fails++;
            $display("%0t: status expected %b actual %b", $time, e.status, m_tuser_i);
          end
          if (e.last !== m_tlast_i) begin
            fails++;
            $display("%0t: last expected %b actual %b", $time, e.last, m_tlast_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          svpd_pkg::RegKind:     kind_r = cfg_data_i[0];
          svpd_pkg::RegDir:      dir_r = cfg_data_i[1:0];
          svpd_pkg::RegULen:     ulen_r = cfg_data_i[4:0];
          svpd_pkg::RegVLen:     vlen_r = cfg_data_i[4:0];
          svpd_pkg::RegWLen:     wlen_r = cfg_data_i[4:0];
          svpd_pkg::RegOrder:    order_r = cfg_data_i[4:0];
          svpd_pkg::RegRational: rational_r = cfg_data_i[0];
          svpd_pkg::RegScalar:   scalar_r = cfg_data_i[0];
          default: ;
        endcase
        ucnt = 0; vcnt = 0; wcnt = 0; wptr = 0;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == svpd_pkg::CmdKnot) knot_mem[s_tdata_i[4:0]] = s_tdata_i[36:5];
        else predict_point(s_tdata_i[68:37]);
      end
    end
  end
endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the spline volume derivative block: directed meshes at the
// extremes, then random phases of knot loads and point streams under random
// idling on both sides, with the verdict taken from the checker.
// ----------------------------------------------------------------------------
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b1;
  logic [31:0] m_data;
  logic        m_user, m_last;
  int          pending, fails;
  int          cycles = 0;
  int          stall_cnt = 0;
  bit          calm = 1'b0;

  always #6 clk_i = ~clk_i;

  spline_volume_partial_derivative dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last)
  );

  svpd_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_tvalid_i(s_valid), .s_tready_i(s_ready), .s_tdata_i(s_data), .s_tuser_i(s_user),
    .m_tvalid_i(m_valid), .m_tready_i(m_ready), .m_tdata_i(m_data),
    .m_tuser_i(m_user), .m_tlast_i(m_last),
    .pending_o(pending), .fails_o(fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("spline_volume_partial_derivative verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int s;
    if (m_valid && m_ready) begin
      s = calm ? 0 : $urandom_range(0, 11);
      if (s > 0) m_ready <= 1'b0;
      stall_cnt <= s;
    end else if (!m_ready) begin
      if (stall_cnt <= 1) m_ready <= 1'b1;
      stall_cnt <= stall_cnt - 1;
    end
  end

  task automatic send_req(input logic cmd, input logic [4:0] idx, input logic [31:0] kv,
                          input logic [31:0] pv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= {3'b000, pv, kv, idx};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic setup(input logic kind, input logic [1:0] dir, input logic [4:0] ul,
                       input logic [4:0] vl, input logic [4:0] wl, input logic [4:0] ord,
                       input logic rat, input logic sc);
    drain();
    write_reg(svpd_pkg::RegKind, {31'd0, kind});
    write_reg(svpd_pkg::RegDir, {30'd0, dir});
    write_reg(svpd_pkg::RegULen, {27'd0, ul});
    write_reg(svpd_pkg::RegVLen, {27'd0, vl});
    write_reg(svpd_pkg::RegWLen, {27'd0, wl});
    write_reg(svpd_pkg::RegOrder, {27'd0, ord});
    write_reg(svpd_pkg::RegRational, {31'd0, rat});
    write_reg(svpd_pkg::RegScalar, {31'd0, sc});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_point();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 2047);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_knots(input bit wide);
    logic [31:0] k;
    k = wide ? $urandom : 32'd0;
    for (int i = 0; i < svpd_pkg::MaxKnots; i++) begin
      if (wide) k = $urandom;
      else if ($urandom_range(0, 3) != 0) k = k + $urandom_range(0, 32'h3_0000);
      send_req(svpd_pkg::CmdKnot, i[4:0], k, $urandom);
    end
  endtask

  function automatic logic [4:0] rand_len();
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'd16;
      2: return 5'd31;
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    logic [4:0] ul, vl, wl, ord;
    int total, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_knots(1'b0);
    // Defaults give a degenerate Bezier with one zero result per point.
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h7fff_ffff);
    setup(1'b0, 2'd0, 5'd16, 5'd1, 5'd1, 5'd1, 1'b0, 1'b0);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h8000_0000);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h7fff_ffff);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h8000_0000);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h0000_0001);
    setup(1'b1, 2'd0, 5'd4, 5'd1, 5'd1, 5'd3, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) send_req(svpd_pkg::CmdKnot, i[4:0], 32'h0001_0000, 32'd0);
    for (int i = 0; i < 4; i++) send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, rand_point());
    setup(1'b1, 2'd1, 5'd2, 5'd2, 5'd1, 5'd1, 1'b0, 1'b0);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h1234_5678);
    setup(1'b0, 2'd2, 5'd1, 5'd1, 5'd2, 5'd2, 1'b1, 1'b0);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h1);
    setup(1'b0, 2'd2, 5'd1, 5'd1, 5'd2, 5'd2, 1'b1, 1'b1);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'hffff_ffff);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h7fff_0000);
    setup(1'b1, 2'd0, 5'd2, 5'd1, 5'd1, 5'd2, 1'b1, 1'b1);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h5);
    setup(1'b0, 2'd3, 5'd2, 5'd1, 5'd1, 5'd2, 1'b0, 1'b0);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h5);
    send_req(svpd_pkg::CmdPoint, 5'd0, 32'd0, 32'h6);
    n = 0;
    while (n < 850) begin
      ul = rand_len();
      vl = rand_len();
      wl = rand_len();
      ord = ($urandom_range(0, 9) == 0) ? 5'd31 : 5'($urandom_range(0, 6));
      setup(1'($urandom_range(0, 1)),
            ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
            ul, vl, wl, ord, $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        load_knots(1'($urandom_range(0, 1)));
        n += svpd_pkg::MaxKnots;
      end
      total = (ul < 1 ? 1 : (ul > 16 ? 16 : ul)) * (vl < 1 ? 1 : (vl > 16 ? 16 : vl)) *
              (wl < 1 ? 1 : (wl > 16 ? 16 : wl));
      if (total > 40) total = $urandom_range(20, 40);
      else total = total + $urandom_range(0, total);
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_req(svpd_pkg::CmdKnot, 5'($urandom_range(0, 31)), $urandom, $urandom);
        send_req(svpd_pkg::CmdPoint, 5'($urandom), $urandom, rand_point());
      end
      n += total;
    end
    calm = 1'b0;
    drain();
    if (fails == 0) begin
      $display("spline_volume_partial_derivative verification clean");
    end else begin
      $display("spline_volume_partial_derivative verification failed");
    end
    $finish;
  end
endmodule
